// ===== rtl/core/sphds_pkg.sv =====
// Package: shared types and constants for the SPH density summation block.
package sphds_pkg;

	localparam int unsigned QW = 32;
	localparam int unsigned SW = 64;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_WEIGHT = 1'd1;

	localparam logic [QW-1:0] SELF_WEIGHT_RST = 32'h0001_0000;
	localparam logic [QW-1:0] MAX32 = '1;

	// Classified term handed from the front part to the back part
	typedef struct packed {
		logic          open_run;
		logic          close_run;
		logic          dens_zero;
		logic [QW-1:0] mass;
		logic [QW-1:0] dens;
		logic [QW-1:0] wt;
	} term_t;

	typedef struct packed {
		logic [QW-1:0] density;
		logic          error;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_FDIV,
		ST_EMIT
	} be_state_t;

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SW] ? '1 : s[SW-1:0];
	endfunction

endpackage

// ===== rtl/core/sphds_if.sv =====
// Interfaces: valid/ready channels for terms and results.
interface sphds_term_if (input logic clk);
	logic is_self;
	logic [31:0] term_mass;
	logic [31:0] term_density;
	logic [31:0] weight;
	logic last;
	logic valid;
	logic ready;
	modport source (output valid, is_self, term_mass, term_density, weight, last, input ready);
	modport sink (input valid, is_self, term_mass, term_density, weight, last, output ready);
endinterface

interface sphds_result_if (input logic clk);
	logic [31:0] density;
	logic error;
	logic valid;
	logic ready;
	modport source (output valid, density, error, input ready);
	modport sink (input valid, density, error, output ready);
endinterface

// ===== rtl/core/sphds_front.sv =====
// Front part: accept terms, pick the weight, flag zero densities.
module sphds_front (
	input  logic                  clk,
	input  logic                  arst_n,
	sphds_term_if.sink            term,
	input  logic [31:0]           self_weight,
	input  logic                  q_full,
	output logic                  push,
	output sphds_pkg::term_t      push_data
);
	assign term.ready = !q_full;
	assign push       = term.valid && !q_full;

	// Classify the transaction
	always_comb begin
		push_data.open_run  = term.is_self;
		push_data.close_run = term.last;
		push_data.dens_zero = (term.term_density == '0);
		push_data.mass      = term.term_mass;
		push_data.dens      = term.term_density;
		push_data.wt        = term.is_self ? self_weight : term.weight;
	end
endmodule

// ===== rtl/core/sphds_queue.sv =====
// Two-entry queue between the front and back parts.
module sphds_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sphds_pkg::term_t      push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output sphds_pkg::term_t      pop_data
);
	sphds_pkg::term_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/core/sphds_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module sphds_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [95:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [95:0] quot
);
	logic [95:0] q_q;
	logic [64:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] r_sh;
	logic [65:0] diff;

	assign r_sh = {r_q[63:0], q_q[95]};
	assign diff = {1'b0, r_sh} - {2'b0, d_q};
	assign quot = q_q;

	// Iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0; cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd95) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend; r_q <= '0; d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[65]) begin
				r_q <= diff[64:0];
				q_q <= {q_q[94:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[94:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/sphds_back.sv =====
// Back part: divide, multiply, accumulate, close runs and drive results.
module sphds_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  normalize,
	input  logic                  not_empty,
	input  sphds_pkg::term_t      head,
	output logic                  pop,
	sphds_result_if.source        res
);
	sphds_pkg::be_state_t st_q, st_d;
	sphds_pkg::term_t cur_q;
	logic [63:0] mass_sum_q, norm_sum_q;
	logic        err_q;
	logic [63:0] mterm_q, nterm_q;
	logic [31:0] qsat_q;
	logic        out_valid_q;
	logic [31:0] out_dens_q;
	logic        out_err_q;
	logic        fdiv_go_q;

	logic        div_start, div_done;
	logic [95:0] div_a, div_q;
	logic [63:0] div_b;
	logic [63:0] m1, n0;
	logic [63:0] fin_sum;

	sphds_div u_div (.clk, .arst_n, .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quot(div_q));

	assign res.valid   = out_valid_q;
	assign res.density = out_dens_q;
	assign res.error   = out_err_q;

	// Divider operands: per-term quotient or final ratio
	always_comb begin
		if (st_q == sphds_pkg::ST_IDLE) begin
			div_a = {48'd0, head.mass, 16'd0};
			div_b = {32'd0, head.dens};
		end else begin
			div_a = {mass_sum_q, 32'd0};
			div_b = norm_sum_q;
		end
	end

	assign m1 = sphds_pkg::sat_add(mass_sum_q, mterm_q);
	assign n0 = sphds_pkg::sat_add(norm_sum_q, nterm_q);
	assign fin_sum = m1;

	// Next state
	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		div_start = 1'b0;
		unique case (st_q)
			sphds_pkg::ST_IDLE: begin
				if (not_empty && !out_valid_q) begin
					pop = 1'b1;
					if (normalize && !head.dens_zero) begin
						div_start = 1'b1; st_d = sphds_pkg::ST_DIV;
					end else begin
						st_d = sphds_pkg::ST_MUL;
					end
				end
			end
			sphds_pkg::ST_DIV: if (div_done) st_d = sphds_pkg::ST_MUL;
			sphds_pkg::ST_MUL: st_d = sphds_pkg::ST_ACC;
			sphds_pkg::ST_ACC: begin
				if (!cur_q.close_run) st_d = sphds_pkg::ST_IDLE;
				else if (normalize && n0 != '0) begin
					st_d = sphds_pkg::ST_FDIV;
				end else st_d = sphds_pkg::ST_EMIT;
			end
			sphds_pkg::ST_FDIV: begin
				// Start the final ratio on entry to the divide state, from the flag registered in the accumulate state
				div_start = fdiv_go_q;
				if (div_done) st_d = sphds_pkg::ST_EMIT;
			end
			sphds_pkg::ST_EMIT: st_d = sphds_pkg::ST_IDLE;
			default: st_d = sphds_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sphds_pkg::ST_IDLE;
			mass_sum_q <= '0; norm_sum_q <= '0; err_q <= 1'b0;
			out_valid_q <= 1'b0; fdiv_go_q <= 1'b0;
			out_dens_q <= '0; out_err_q <= 1'b0;
		end else begin
			st_q <= st_d;
			fdiv_go_q <= 1'b0;
			if (out_valid_q && res.ready) out_valid_q <= 1'b0;
			unique case (st_q)
				sphds_pkg::ST_IDLE: begin
					if (pop && head.open_run) begin
						mass_sum_q <= '0; norm_sum_q <= '0; err_q <= 1'b0;
					end
					if (pop && normalize && head.dens_zero) err_q <= 1'b1 | (err_q & !head.open_run);
				end
				sphds_pkg::ST_ACC: begin
					mass_sum_q <= m1;
					if (normalize && !cur_q.dens_zero) norm_sum_q <= n0;
					if (cur_q.close_run && normalize && n0 != '0) fdiv_go_q <= 1'b1;
					if (cur_q.close_run && !(normalize && n0 != '0)) begin
						out_dens_q <= normalize ? '0 :
							(fin_sum[63:32] != '0 ? sphds_pkg::MAX32 : fin_sum[31:0]);
						out_err_q <= err_q | normalize;
					end
				end
				sphds_pkg::ST_FDIV: begin
					if (div_done) begin
						out_dens_q <= (div_q[95:48] != '0) ? sphds_pkg::MAX32 : div_q[47:16];
						out_err_q  <= err_q;
					end
				end
				sphds_pkg::ST_EMIT: begin
					out_valid_q <= 1'b1;
					mass_sum_q <= '0; norm_sum_q <= '0; err_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (st_q == sphds_pkg::ST_DIV && div_done)
			qsat_q <= (div_q[95:32] != '0) ? sphds_pkg::MAX32 : div_q[31:0];
		if (st_q == sphds_pkg::ST_MUL) begin
			mterm_q <= ({32'd0, cur_q.mass} * {32'd0, cur_q.wt}) >> 16;
			nterm_q <= ({32'd0, qsat_q} * {32'd0, cur_q.wt}) >> 16;
		end
		if (st_q == sphds_pkg::ST_IDLE && pop && !(normalize && !head.dens_zero))
			qsat_q <= '0;
	end
endmodule

// ===== rtl/core/sph_density_summation.sv =====
// Top level: SPH density summation with optional Shepard normalization.
//
// Usage: terms arrive on the term channel (valid/ready); a self term opens a
// run and resets the sums, neighbour terms add to them, and the term marked
// last yields one result on the result channel. Configuration is a plain
// write port (cfg_we, cfg_index, cfg_data): index 0 is normalize, index 1 is
// self_weight. The user must write them only while the block is idle; the
// block itself does not enforce this. Each term passes the multiply and
// accumulate states; in normalized mode a term with a nonzero density first
// passes the divider, which forms mass over density one quotient bit per
// cycle. The last term of a run adds an emit state, plus a second divider
// pass for the final ratio in normalized mode when the normalizer sum is
// nonzero. The front part queues terms in a two-entry queue, so the term
// channel keeps accepting while the back part works.
// Reset clears the sums, error flag, queue and output register; normalize
// resets to 0 and self_weight to 1.0. If the receiver stalls, the result
// stays in the output register and the back part waits; the queue fills and
// then the term channel deasserts ready.
module sph_density_summation (
	input  logic        clk,
	input  logic        arst_n,
	sphds_term_if.sink  term,
	sphds_result_if.source res,
	input  logic        cfg_we,
	input  logic [sphds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	logic        normalize_q;
	logic [31:0] self_weight_q;
	logic        q_full, push, pop, not_empty;
	sphds_pkg::term_t push_data, head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normalize_q <= 1'b0;
			self_weight_q <= sphds_pkg::SELF_WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sphds_pkg::REG_NORMALIZE:   normalize_q <= cfg_data[0];
				sphds_pkg::REG_SELF_WEIGHT: self_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sphds_front u_front (.clk, .arst_n, .term, .self_weight(self_weight_q),
		.q_full, .push, .push_data);

	sphds_queue u_queue (.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop, .not_empty, .pop_data(head));

	sphds_back u_back (.clk, .arst_n, .normalize(normalize_q), .not_empty,
		.head, .pop, .res);
endmodule

// ===== dv/sphds_checker.sv =====
// Checker: predicts each density result from the observed terms and compares it.
module sphds_checker (
	input  logic            clk,
	input  logic            arst_n,
	sphds_term_if           term,
	sphds_result_if         res,
	input  logic            cfg_we,
	input  logic [sphds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]     cfg_data,
	output int              fails,
	output int              pending,
	output int              terms_seen,
	output int              results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import sphds_pkg::*;

	// Predictor state and configuration copy
	logic [SW-1:0] acc_mass;
	logic [SW-1:0] acc_norm;
	logic          acc_err;
	logic          cfg_norm;
	logic [QW-1:0] cfg_self_w;
	result_t       density_expq[$];

	function automatic logic [SW-1:0] add_clamp(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SW] ? {SW{1'b1}} : s[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] q_product(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [SW-1:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p >> 16;
	endfunction

	// Q16.16 ratio of two 64-bit sums, restoring one fraction bit per step
	function automatic logic [QW-1:0] q_ratio(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW-1:0] q;
		logic [SW-1:0] r;
		q = a / b;
		r = a % b;
		if (q > 64'hFFFF)
			return MAX32;
		for (int i = 0; i < 16; i++) begin
			q = q << 1;
			if (r >= b - r) begin
				r = r - (b - r);
				q[0] = 1'b1;
			end else begin
				r = r << 1;
			end
		end
		return (q > 64'hFFFF_FFFF) ? MAX32 : q[QW-1:0];
	endfunction

	// Fold one accepted term into the sums; queue the density on a closing term
	task automatic fold_term(input logic self_t, input logic [QW-1:0] m, input logic [QW-1:0] d,
			input logic [QW-1:0] w, input logic close_t);
		logic [QW-1:0] wt;
		logic [SW-1:0] quo;
		result_t       r;
		if (self_t) begin
			acc_mass = '0;
			acc_norm = '0;
			acc_err  = 1'b0;
			wt = cfg_self_w;
		end else begin
			wt = w;
		end
		acc_mass = add_clamp(acc_mass, q_product(m, wt));
		if (cfg_norm) begin
			if (d == '0) begin
				acc_err = 1'b1;
			end else begin
				quo = ({32'd0, m} << 16) / {32'd0, d};
				if (quo > 64'hFFFF_FFFF)
					quo = 64'hFFFF_FFFF;
				acc_norm = add_clamp(acc_norm, q_product(quo[QW-1:0], wt));
			end
		end
		if (close_t) begin
			r.error = acc_err;
			if (cfg_norm) begin
				if (acc_norm == '0) begin
					r.error   = 1'b1;
					r.density = '0;
				end else begin
					r.density = q_ratio(acc_mass, acc_norm);
				end
			end else begin
				r.density = (acc_mass > 64'hFFFF_FFFF) ? MAX32 : acc_mass[QW-1:0];
			end
			density_expq.push_back(r);
			acc_mass = '0;
			acc_norm = '0;
			acc_err  = 1'b0;
		end
	endtask

	// Track configuration, terms and results at each rising edge
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			acc_mass     = '0;
			acc_norm     = '0;
			acc_err      = 1'b0;
			cfg_norm     = 1'b0;
			cfg_self_w   = SELF_WEIGHT_RST;
			density_expq.delete();
			fails        <= 0;
			pending      <= 0;
			terms_seen   <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NORMALIZE)
					cfg_norm = cfg_data[0];
				else if (cfg_index == REG_SELF_WEIGHT)
					cfg_self_w = cfg_data;
			end
			if (term.valid && term.ready) begin
				fold_term(term.is_self, term.term_mass, term.term_density, term.weight, term.last);
				terms_seen <= terms_seen + 1;
			end
			if (res.valid && res.ready) begin
				results_seen <= results_seen + 1;
				if (density_expq.size() == 0) begin
					$error("unexpected result: density %h error %b", res.density, res.error);
					fails <= fails + 1;
				end else begin
					exp_r = density_expq.pop_front();
					if (res.density !== exp_r.density) begin
						$error("density: expected %h, actual %h", exp_r.density, res.density);
						fails <= fails + 1;
					end
					if (res.error !== exp_r.error) begin
						$error("error: expected %b, actual %b", exp_r.error, res.error);
						fails <= fails + 1;
					end
				end
			end
			pending <= density_expq.size();
		end
	end

endmodule

// ===== dv/sph_density_summation_test.sv =====
// Testbench top: drives terms, configuration and result backpressure; gives the verdict.
module sph_density_summation_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sphds_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   fails;
	int                   pending;
	int                   terms_seen;
	int                   results_seen;
	int                   norm_phases;
	bit                   send_idle;

	sphds_term_if   term (clk);
	sphds_result_if res (clk);

	sph_density_summation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.term      (term),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sphds_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.term         (term),
		.res          (res),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fails        (fails),
		.pending      (pending),
		.terms_seen   (terms_seen),
		.results_seen (results_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Mix extremes, values near 1.0 and full-range values
	function automatic logic [31:0] pick_q();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0001_0000 + $urandom_range(0, 32'hFFFF);
			3: return $urandom_range(1, 32'hFF);
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Present one term, after a random gap if send_idle is set, and hold it until the transaction
	task automatic send_term(input logic s, input logic [31:0] m, input logic [31:0] d,
			input logic [31:0] w, input logic l);
		int gap;
		gap = send_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			term.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		term.valid        <= 1'b1;
		term.is_self      <= s;
		term.term_mass    <= m;
		term.term_density <= d;
		term.weight       <= w;
		term.last         <= l;
		do @(posedge clk); while (!term.ready);
	endtask

	// Drain all results, then let any queued terms settle before a register write
	task automatic wait_idle();
		term.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic set_mode(input logic nrm, input logic [31:0] sw);
		wait_idle();
		write_reg(REG_NORMALIZE, {31'd0, nrm});
		write_reg(REG_SELF_WEIGHT, sw);
		if (nrm)
			norm_phases++;
	endtask

	// Result side backpressure: random stall before each transaction
	initial begin
		int gap;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	// Stimulus
	initial begin
		int nb;
		int sent;
		term.valid        = 1'b0;
		term.is_self      = 1'b0;
		term.term_mass    = '0;
		term.term_density = '0;
		term.weight       = '0;
		term.last         = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_NORMALIZE;
		cfg_data          = '0;
		arst_n            = 1'b0;
		send_idle         = 1'b1;
		norm_phases       = 0;
		sent              = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain mode at reset values: neighbour without self, single-term run, clamp
		send_term(1'b0, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 1'b0);
		send_term(1'b0, 32'h0001_0000, 32'd0, 32'h0001_0000, 1'b1);
		send_term(1'b1, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1);
		send_term(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
		send_term(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_term(1'b1, 32'd0, 32'd0, 32'd0, 1'b1);

		// Normalized mode: zero density, zero normalizer, ratio overflow, normal run
		set_mode(1'b1, 32'h0001_0000);
		send_term(1'b1, 32'h0001_0000, 32'h0002_0000, 32'd0, 1'b0);
		send_term(1'b0, 32'h0002_0000, 32'd0, 32'h0000_4000, 1'b0);
		send_term(1'b0, 32'h0001_8000, 32'h0001_0000, 32'h0000_8000, 1'b1);
		send_term(1'b1, 32'd0, 32'h0001_0000, 32'd0, 1'b0);
		send_term(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
		send_term(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
		send_term(1'b1, 32'h0001_0000, 32'h0000_0001, 32'd0, 1'b1);
		send_term(1'b0, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 1'b0);
		send_term(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h1234_5678, 1'b0);
		send_term(1'b0, 32'h0002_0000, 32'h0003_0000, 32'h0000_C000, 1'b1);

		// Hold off until every result is back, then continue
		term.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_mode(1'b0, 32'h0001_0000);
				1: set_mode(1'b1, 32'hFFFF_FFFF);
				2: set_mode(1'b0, 32'hFFFF_FFFF);
				3: set_mode(1'b1, 32'd0);
				4: set_mode(1'b0, 32'd0);
				5: set_mode(1'b1, $urandom);
				6: set_mode(1'b0, $urandom);
				default: set_mode(1'b1, 32'h0001_0000);
			endcase
			send_idle = ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < 190) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: any flag combination with any values
					send_term(1'($urandom_range(0, 1)), pick_q(), pick_q(), pick_q(),
						1'($urandom_range(0, 1)));
					sent++;
				end else begin
					nb = $urandom_range(0, 5);
					send_term(1'b1, pick_q(), pick_q(), pick_q(), nb == 0);
					for (int k = 0; k < nb; k++)
						send_term(1'b0, pick_q(), pick_q(), pick_q(), k == nb - 1);
					sent += nb + 1;
				end
			end
			// close any run left open so the phase ends with nothing in flight
			send_term(1'b0, pick_q(), pick_q(), pick_q(), 1'b1);
		end

		term.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
		$display("covered %0d terms and %0d densities over plain and %0d normalized settings",
			terms_seen, results_seen, norm_phases);
		$display("self weights included zero, 1.0 and all ones; gaps and stalls were random");
		if (fails == 0)
			$display("sph_density_summation_test: done, clean");
		else
			$display("sph_density_summation_test: done, errors");
		$finish;
	end

	// Guard against a hang
	initial begin
		#20ms;
		$display("sph_density_summation_test: done, errors");
		$finish;
	end

endmodule
